@@ hdl/vipc_pkg.sv @@
// Shared types, register offsets and constants of the vectored interrupt controller.
`default_nettype none

package vipc_pkg;

    localparam int NUM_SOURCES_DEF = 32;
    localparam int NUM_LEVELS_DEF  = 16;

    localparam int DATA_W  = 32;
    localparam int OFF_W   = 16;
    localparam int LINE_W  = 6;
    localparam int LVL_W   = 4;
    localparam int CEIL_W  = 5;
    localparam int SLOT_W  = 6;
    localparam int IDX_W   = 5;
    localparam int MASK_W  = 16;
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 72;

    localparam logic [SLOT_W-1:0] DAISY_SLOT = 6'd32;
    localparam logic [SLOT_W-1:0] NO_SOURCE  = 6'd33;

    localparam logic [OFF_W-1:0] OFF_IRQ_STATUS = 16'h000;
    localparam logic [OFF_W-1:0] OFF_FIQ_STATUS = 16'h004;
    localparam logic [OFF_W-1:0] OFF_RAW_STATUS = 16'h008;
    localparam logic [OFF_W-1:0] OFF_FIQ_SELECT = 16'h00C;
    localparam logic [OFF_W-1:0] OFF_EN_SET     = 16'h010;
    localparam logic [OFF_W-1:0] OFF_EN_CLR     = 16'h014;
    localparam logic [OFF_W-1:0] OFF_SOFT_SET   = 16'h018;
    localparam logic [OFF_W-1:0] OFF_SOFT_CLR   = 16'h01C;
    localparam logic [OFF_W-1:0] OFF_PROTECT    = 16'h020;
    localparam logic [OFF_W-1:0] OFF_PRIO_MASK  = 16'h024;
    localparam logic [OFF_W-1:0] OFF_DAISY_PRIO = 16'h028;
    localparam logic [OFF_W-1:0] OFF_VEC_BASE   = 16'h100;
    localparam logic [OFF_W-1:0] OFF_VEC_END    = 16'h180;
    localparam logic [OFF_W-1:0] OFF_PRIO_BASE  = 16'h200;
    localparam logic [OFF_W-1:0] OFF_PRIO_END   = 16'h280;
    localparam logic [OFF_W-1:0] OFF_ADDRESS    = 16'hF00;
    localparam logic [OFF_W-1:0] OFF_ID_BASE    = 16'hFE0;
    localparam logic [OFF_W-1:0] OFF_LIMIT      = 16'h1000;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LINE  = 2'd2,
        OP_DAISY = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD_WAIT,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_SCAN_DAISY,
        ST_POST,
        ST_VEC_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [OFF_W-1:0]  offset;
        logic              privileged;
        logic [DATA_W-1:0] write_data;
        logic [LINE_W-1:0] line_index;
        logic              line_level;
        logic              daisy_irq_in;
        logic              daisy_fiq_in;
        logic [DATA_W-1:0] daisy_vector_in;
    } item_t;

    function automatic logic [7:0] id_byte(input logic [2:0] sel);
        logic [7:0] b;
        case (sel)
            3'd0:    b = 8'h92;
            3'd1:    b = 8'h11;
            3'd2:    b = 8'h04;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h0d;
            3'd5:    b = 8'hf0;
            3'd6:    b = 8'h05;
            default: b = 8'hb1;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ hdl/vectored_interrupt_priority_controller_core.sv @@
// Top level of the 32-source vectored interrupt controller with daisy input.
//
//  channel | ports              | word
//  --------+--------------------+---------------------------------------------
//  input   | s_tvalid/s_tready  | s_tuser: op; s_tdata: bus access or line/daisy update
//  result  | m_tvalid/m_tready  | m_tdata: ok, read data, irq, fiq, latched vector
//
// For each word the priority scan reads one source level per cycle from the level RAM
// through the shared compare unit, then the daisy slot.
// Vector/priority reads add a RAM wait state; an address register read scans twice.
// Reset is synchronous; RAM contents are covered by per-entry valid bits, no clearing pass.
// s_tready is high only between words; a result waiting on m_tready holds the block.
`default_nettype none

module vectored_interrupt_priority_controller_core #(
    parameter int NUM_SOURCES = vipc_pkg::NUM_SOURCES_DEF,
    parameter int NUM_LEVELS  = vipc_pkg::NUM_LEVELS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // offset[15:0], privileged[16], write_data[48:17], line_index[54:49], line_level[55],
    // daisy_irq_in[56], daisy_fiq_in[57], daisy_vector_in[89:58], zero fill
    input  wire logic [vipc_pkg::S_DATA_W-1:0] s_tdata,
    // op[1:0]
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // ok[0], read_data[32:1], irq_out[33], fiq_out[34], vector_now[66:35], zero fill
    output logic      [vipc_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int SW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam logic [31:0] SRC_MASK = 32'hFFFF_FFFF >> (32 - NUM_SOURCES);
    localparam logic [vipc_pkg::LVL_W-1:0]  MAX_LVL  = vipc_pkg::LVL_W'(NUM_LEVELS - 1);
    localparam logic [vipc_pkg::CEIL_W-1:0] TOP_CEIL = vipc_pkg::CEIL_W'(NUM_LEVELS);
    localparam logic [vipc_pkg::SLOT_W-1:0] NSRC     = vipc_pkg::SLOT_W'(NUM_SOURCES);
    localparam logic [31:0] NLVL32 = 32'(NUM_LEVELS);

    vipc_pkg::state_t state_reg, state_next;
    vipc_pkg::item_t  item_reg;

    logic [31:0] line_reg, line_next, soft_reg, soft_next;
    logic [31:0] en_reg, en_next, fsel_reg, fsel_next;
    logic        protect_reg, protect_next;
    logic [15:0] mask_reg, mask_next;
    logic [3:0]  dlvl_reg, dlvl_next;
    logic [15:0] active_reg, active_next;
    logic [31:0] latched_reg, latched_next;
    logic        dirq_reg, dirq_next, dfiq_reg, dfiq_next;
    logic [31:0] dvec_reg, dvec_next;
    logic [NUM_SOURCES-1:0] vvalid_reg, vvalid_next, lvalid_reg, lvalid_next;
    logic        ok_reg, ok_next;
    logic [31:0] rdata_reg, rdata_next;
    logic        refresh_reg, refresh_next, addr_rd_reg, addr_rd_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        pipe_vld_reg, pipe_vld_next;
    logic [4:0]  pipe_idx_reg, pipe_idx_next;
    logic [5:0]  best_src_reg, best_src_next;
    logic [4:0]  best_lvl_reg, best_lvl_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [vipc_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic          vram_we, lram_we;
    logic [SW-1:0] vram_raddr, lram_raddr, ram_waddr;
    logic [31:0]   vram_q;
    logic [3:0]    lram_q;

    logic [15:0] off;
    logic        bus_acc, in_vec, in_prio, in_id, idx_ok, ram_rd_req;
    logic [4:0]  reg_idx;
    logic [31:0] pend, irq_vec, fiq_vec;
    logic [4:0]  ceil_init;
    logic        cand_vld, cand_req, cand_wins;
    logic [3:0]  cand_lvl;
    logic [5:0]  cand_src;
    logic        out_free;

    vipc_ram #(.WIDTH(32), .DEPTH(NUM_SOURCES), .AW(SW)) u_vec_ram (
        .aclk  (aclk),
        .we    (vram_we),
        .waddr (ram_waddr),
        .wdata (item_reg.write_data),
        .raddr (vram_raddr),
        .rdata (vram_q)
    );

    vipc_ram #(.WIDTH(4), .DEPTH(NUM_SOURCES), .AW(SW)) u_lvl_ram (
        .aclk  (aclk),
        .we    (lram_we),
        .waddr (ram_waddr),
        .wdata (item_reg.write_data[3:0]),
        .raddr (lram_raddr),
        .rdata (lram_q)
    );

    // decode of the held word
    assign off       = item_reg.offset;
    assign bus_acc   = (off[1:0] == 2'b00) && (off < vipc_pkg::OFF_LIMIT) &&
                       (item_reg.privileged || (!protect_reg && off != vipc_pkg::OFF_PROTECT));
    assign in_vec    = (off >= vipc_pkg::OFF_VEC_BASE) && (off < vipc_pkg::OFF_VEC_END);
    assign in_prio   = (off >= vipc_pkg::OFF_PRIO_BASE) && (off < vipc_pkg::OFF_PRIO_END);
    assign in_id     = (off >= vipc_pkg::OFF_ID_BASE);
    assign reg_idx   = off[6:2];
    assign idx_ok    = {1'b0, reg_idx} < NSRC;
    assign ram_waddr = reg_idx[SW-1:0];
    assign ram_rd_req = (item_reg.op == vipc_pkg::OP_READ) && bus_acc &&
                        (in_vec || in_prio) && idx_ok;

    assign pend    = (line_reg | soft_reg) & SRC_MASK;
    assign irq_vec = pend & en_reg & ~fsel_reg;
    assign fiq_vec = pend & en_reg & fsel_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        ceil_init = TOP_CEIL;
        for (int i = 15; i >= 0; i--) begin
            if (active_reg[i]) begin
                ceil_init = 5'(i);
            end
        end
    end

    // shared compare unit
    always_comb begin
        if (state_reg == vipc_pkg::ST_SCAN_DAISY) begin
            cand_vld = 1'b1;
            cand_req = dirq_reg;
            cand_lvl = dlvl_reg;
            cand_src = vipc_pkg::DAISY_SLOT;
        end else begin
            cand_vld = (state_reg == vipc_pkg::ST_SCAN) && pipe_vld_reg;
            cand_req = irq_vec[pipe_idx_reg];
            cand_lvl = lvalid_reg[pipe_idx_reg[SW-1:0]] ? lram_q : MAX_LVL;
            cand_src = {1'b0, pipe_idx_reg};
        end
        cand_wins = cand_vld && cand_req && ({1'b0, cand_lvl} < best_lvl_reg) &&
                    mask_reg[cand_lvl];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            vipc_pkg::ST_IDLE:       if (s_tvalid) state_next = vipc_pkg::ST_EXEC;
            vipc_pkg::ST_EXEC:       state_next = ram_rd_req ? vipc_pkg::ST_RD_WAIT
                                                             : vipc_pkg::ST_SCAN_INIT;
            vipc_pkg::ST_RD_WAIT:    state_next = vipc_pkg::ST_SCAN_INIT;
            vipc_pkg::ST_SCAN_INIT:  state_next = vipc_pkg::ST_SCAN;
            vipc_pkg::ST_SCAN:       if (cnt_reg >= NSRC) state_next = vipc_pkg::ST_SCAN_DAISY;
            vipc_pkg::ST_SCAN_DAISY: state_next = vipc_pkg::ST_POST;
            vipc_pkg::ST_POST: begin
                if (addr_rd_reg) begin
                    state_next = vipc_pkg::ST_SCAN_INIT;
                end else if (refresh_reg && best_src_reg < vipc_pkg::DAISY_SLOT) begin
                    state_next = vipc_pkg::ST_VEC_WAIT;
                end else begin
                    state_next = vipc_pkg::ST_FINISH;
                end
            end
            vipc_pkg::ST_VEC_WAIT:   state_next = vipc_pkg::ST_FINISH;
            vipc_pkg::ST_FINISH:     if (out_free) state_next = vipc_pkg::ST_IDLE;
            default:                 state_next = vipc_pkg::ST_IDLE;
        endcase
    end

    // RAM control and handshake outputs
    always_comb begin
        s_tready   = (state_reg == vipc_pkg::ST_IDLE);
        vram_we    = (state_reg == vipc_pkg::ST_EXEC) && (item_reg.op == vipc_pkg::OP_WRITE) &&
                     bus_acc && in_vec && idx_ok;
        lram_we    = (state_reg == vipc_pkg::ST_EXEC) && (item_reg.op == vipc_pkg::OP_WRITE) &&
                     bus_acc && in_prio && idx_ok && (item_reg.write_data < NLVL32);
        vram_raddr = (state_reg == vipc_pkg::ST_POST) ? best_src_reg[SW-1:0] : reg_idx[SW-1:0];
        lram_raddr = (state_reg == vipc_pkg::ST_SCAN) ? cnt_reg[SW-1:0] : reg_idx[SW-1:0];
    end

    // datapath
    always_comb begin
        line_next = line_reg;       soft_next = soft_reg;
        en_next = en_reg;           fsel_next = fsel_reg;
        protect_next = protect_reg; mask_next = mask_reg;
        dlvl_next = dlvl_reg;       active_next = active_reg;
        latched_next = latched_reg;
        dirq_next = dirq_reg;       dfiq_next = dfiq_reg;   dvec_next = dvec_reg;
        vvalid_next = vvalid_reg;   lvalid_next = lvalid_reg;
        ok_next = ok_reg;           rdata_next = rdata_reg;
        refresh_next = refresh_reg; addr_rd_next = addr_rd_reg;
        cnt_next = cnt_reg;         pipe_vld_next = pipe_vld_reg; pipe_idx_next = pipe_idx_reg;
        best_src_next = best_src_reg; best_lvl_next = best_lvl_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next = m_tdata_reg;

        if (vram_we) vvalid_next[reg_idx[SW-1:0]] = 1'b1;
        if (lram_we) lvalid_next[reg_idx[SW-1:0]] = 1'b1;

        if (cand_wins) begin
            best_src_next = cand_src;
            best_lvl_next = {1'b0, cand_lvl};
        end

        case (state_reg)
            vipc_pkg::ST_EXEC: begin
                ok_next      = 1'b0;
                rdata_next   = '0;
                refresh_next = 1'b0;
                addr_rd_next = 1'b0;
                case (item_reg.op)
                    vipc_pkg::OP_READ: begin
                        if (bus_acc) begin
                            if (in_vec || in_prio) begin
                                ok_next = idx_ok;
                            end else if (in_id) begin
                                ok_next    = 1'b1;
                                rdata_next = {24'd0, vipc_pkg::id_byte(off[4:2])};
                            end else begin
                                ok_next = 1'b1;
                                unique case (off)
                                    vipc_pkg::OFF_IRQ_STATUS: rdata_next = irq_vec;
                                    vipc_pkg::OFF_FIQ_STATUS: rdata_next = fiq_vec;
                                    vipc_pkg::OFF_RAW_STATUS: rdata_next = pend;
                                    vipc_pkg::OFF_FIQ_SELECT: rdata_next = fsel_reg;
                                    vipc_pkg::OFF_EN_SET:     rdata_next = en_reg;
                                    vipc_pkg::OFF_SOFT_SET:   rdata_next = soft_reg;
                                    vipc_pkg::OFF_PROTECT:    rdata_next = {31'd0, protect_reg};
                                    vipc_pkg::OFF_PRIO_MASK:  rdata_next = {16'd0, mask_reg};
                                    vipc_pkg::OFF_DAISY_PRIO: rdata_next = {28'd0, dlvl_reg};
                                    vipc_pkg::OFF_ADDRESS: begin
                                        rdata_next   = latched_reg;
                                        addr_rd_next = 1'b1;
                                    end
                                    default: ok_next = 1'b0;
                                endcase
                            end
                        end
                    end
                    vipc_pkg::OP_WRITE: begin
                        if (bus_acc) begin
                            if (in_vec) begin
                                ok_next = idx_ok;
                            end else if (in_prio) begin
                                ok_next = idx_ok && (item_reg.write_data < NLVL32);
                            end else begin
                                ok_next = 1'b1;
                                unique case (off)
                                    vipc_pkg::OFF_FIQ_SELECT:
                                        fsel_next = item_reg.write_data & SRC_MASK;
                                    vipc_pkg::OFF_EN_SET:
                                        en_next = (en_reg | item_reg.write_data) & SRC_MASK;
                                    vipc_pkg::OFF_EN_CLR:
                                        en_next = en_reg & ~item_reg.write_data;
                                    vipc_pkg::OFF_SOFT_SET:
                                        soft_next = (soft_reg | item_reg.write_data) & SRC_MASK;
                                    vipc_pkg::OFF_SOFT_CLR:
                                        soft_next = soft_reg & ~item_reg.write_data;
                                    vipc_pkg::OFF_PROTECT: begin
                                        if (item_reg.write_data[31:1] == '0) begin
                                            protect_next = item_reg.write_data[0];
                                        end else begin
                                            ok_next = 1'b0;
                                        end
                                    end
                                    vipc_pkg::OFF_PRIO_MASK: begin
                                        if (item_reg.write_data[31:16] == '0) begin
                                            mask_next = item_reg.write_data[15:0];
                                        end else begin
                                            ok_next = 1'b0;
                                        end
                                    end
                                    vipc_pkg::OFF_DAISY_PRIO: begin
                                        if (item_reg.write_data < NLVL32) begin
                                            dlvl_next = item_reg.write_data[3:0];
                                        end else begin
                                            ok_next = 1'b0;
                                        end
                                    end
                                    vipc_pkg::OFF_ADDRESS:
                                        active_next = active_reg & (active_reg - 16'd1);
                                    default: ok_next = 1'b0;
                                endcase
                            end
                            refresh_next = ok_next;
                        end
                    end
                    vipc_pkg::OP_LINE: begin
                        if (item_reg.line_index < NSRC) begin
                            line_next[item_reg.line_index[4:0]] = item_reg.line_level;
                            ok_next      = 1'b1;
                            refresh_next = 1'b1;
                        end
                    end
                    default: begin
                        dirq_next    = item_reg.daisy_irq_in;
                        dfiq_next    = item_reg.daisy_fiq_in;
                        dvec_next    = item_reg.daisy_vector_in;
                        ok_next      = 1'b1;
                        refresh_next = 1'b1;
                    end
                endcase
            end
            vipc_pkg::ST_RD_WAIT: begin
                if (in_vec) begin
                    rdata_next = vvalid_reg[reg_idx[SW-1:0]] ? vram_q : 32'd0;
                end else begin
                    rdata_next = {28'd0, lvalid_reg[reg_idx[SW-1:0]] ? lram_q : MAX_LVL};
                end
            end
            vipc_pkg::ST_SCAN_INIT: begin
                cnt_next      = '0;
                pipe_vld_next = 1'b0;
                best_src_next = vipc_pkg::NO_SOURCE;
                best_lvl_next = ceil_init;
            end
            vipc_pkg::ST_SCAN: begin
                if (cnt_reg < NSRC) begin
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = cnt_reg[4:0];
                    cnt_next      = cnt_reg + 6'd1;
                end else begin
                    pipe_vld_next = 1'b0;
                end
            end
            vipc_pkg::ST_POST: begin
                if (addr_rd_reg) begin
                    if (best_src_reg != vipc_pkg::NO_SOURCE && !best_lvl_reg[4]) begin
                        active_next[best_lvl_reg[3:0]] = 1'b1;
                    end
                    addr_rd_next = 1'b0;
                    refresh_next = 1'b1;
                end else if (refresh_reg && best_src_reg == vipc_pkg::DAISY_SLOT) begin
                    latched_next = dvec_reg;
                end
            end
            vipc_pkg::ST_VEC_WAIT: begin
                latched_next = vvalid_reg[best_src_reg[SW-1:0]] ? vram_q : 32'd0;
            end
            vipc_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, latched_reg, ((|fiq_vec) || dfiq_reg),
                                     (best_src_reg != vipc_pkg::NO_SOURCE), rdata_reg, ok_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= vipc_pkg::ST_IDLE;
            line_reg     <= '0;
            soft_reg     <= '0;
            en_reg       <= '0;
            fsel_reg     <= '0;
            protect_reg  <= 1'b0;
            mask_reg     <= 16'hFFFF;
            dlvl_reg     <= MAX_LVL;
            active_reg   <= '0;
            latched_reg  <= '0;
            dirq_reg     <= 1'b0;
            dfiq_reg     <= 1'b0;
            dvec_reg     <= '0;
            vvalid_reg   <= '0;
            lvalid_reg   <= '0;
            refresh_reg  <= 1'b0;
            addr_rd_reg  <= 1'b0;
            cnt_reg      <= '0;
            pipe_vld_reg <= 1'b0;
            best_src_reg <= vipc_pkg::NO_SOURCE;
            best_lvl_reg <= TOP_CEIL;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            line_reg     <= line_next;
            soft_reg     <= soft_next;
            en_reg       <= en_next;
            fsel_reg     <= fsel_next;
            protect_reg  <= protect_next;
            mask_reg     <= mask_next;
            dlvl_reg     <= dlvl_next;
            active_reg   <= active_next;
            latched_reg  <= latched_next;
            dirq_reg     <= dirq_next;
            dfiq_reg     <= dfiq_next;
            dvec_reg     <= dvec_next;
            vvalid_reg   <= vvalid_next;
            lvalid_reg   <= lvalid_next;
            refresh_reg  <= refresh_next;
            addr_rd_reg  <= addr_rd_next;
            cnt_reg      <= cnt_next;
            pipe_vld_reg <= pipe_vld_next;
            best_src_reg <= best_src_next;
            best_lvl_reg <= best_lvl_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.op              <= vipc_pkg::op_t'(s_tuser);
            item_reg.offset          <= s_tdata[15:0];
            item_reg.privileged      <= s_tdata[16];
            item_reg.write_data      <= s_tdata[48:17];
            item_reg.line_index      <= s_tdata[54:49];
            item_reg.line_level      <= s_tdata[55];
            item_reg.daisy_irq_in    <= s_tdata[56];
            item_reg.daisy_fiq_in    <= s_tdata[57];
            item_reg.daisy_vector_in <= s_tdata[89:58];
        end
        ok_reg        <= ok_next;
        rdata_reg     <= rdata_next;
        pipe_idx_reg  <= pipe_idx_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("word accepted while previous word in progress");

    a_winner_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        best_src_reg < NSRC || best_src_reg == vipc_pkg::DAISY_SLOT ||
        best_src_reg == vipc_pkg::NO_SOURCE)
        else $error("winner slot out of range");

    a_winner_level: assert property (@(posedge aclk) disable iff (!aresetn)
        best_src_reg != vipc_pkg::NO_SOURCE |-> best_lvl_reg < TOP_CEIL)
        else $error("winner level out of range");

    a_scan_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= NSRC)
        else $error("scan counter overrun");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == vipc_pkg::ST_FINISH))
        else $error("result raised outside finish state");

endmodule

`default_nettype wire

@@ hdl/vipc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module vipc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
